// ----- hw/rtl/utf8d_pkg.sv -----
// utf8d_pkg: shared types and constants for the UTF-8 validating decoder.
// Depends on nothing; used by the core, the result queue, the top level
// and the checker.
package utf8d_pkg;

    // Result status codes
    localparam logic [1:0] ST_CHAR       = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    // Field widths
    localparam int CP_W  = 31;
    localparam int CNT_W = 3;

    // One result beat
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [1:0]       status;
        logic [CNT_W-1:0] byte_count;
        logic             last_of_run;
    } result_t;

    // Results produced by one byte, handed to the result queue
    typedef struct packed {
        logic [1:0] num;    // 0, 1 or 2 results
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

// ----- hw/rtl/utf8d_core.sv -----
// utf8d_core: input register, sequence state and single-pass byte decode.
// Depends on utf8d_pkg (result_t, push_t, status codes).
module utf8d_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // input byte channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_data,
    // configuration
    input  logic                 cfg_we,
    input  logic                 cfg_strict,
    // result queue side
    input  logic                 space_ok,
    output utf8d_pkg::push_t     push
);

    // decode of a byte while no sequence is open
    typedef struct packed {
        logic               emit;
        utf8d_pkg::result_t res;
        logic [2:0]         len;
        logic [4:0]         payload;
    } lead_t;

    function automatic lead_t lead_decode(input logic [7:0] b, input logic eod);
        lead_t r;
        r = '0;
        r.res.byte_count = 3'd1;
        if (b < 8'h80) begin
            r.emit = 1'b1;
            r.res.status = utf8d_pkg::ST_CHAR;
            r.res.code_point = {23'd0, b};
        end else if (b < 8'hC0 || b >= 8'hFE) begin
            r.emit = 1'b1;
            r.res.status = utf8d_pkg::ST_INVALID;
        end else begin
            if (b < 8'hE0) begin
                r.len = 3'd2;
                r.payload = b[4:0];
            end else if (b < 8'hF0) begin
                r.len = 3'd3;
                r.payload = {1'b0, b[3:0]};
            end else if (b < 8'hF8) begin
                r.len = 3'd4;
                r.payload = {2'b0, b[2:0]};
            end else if (b < 8'hFC) begin
                r.len = 3'd5;
                r.payload = {3'b0, b[1:0]};
            end else begin
                r.len = 3'd6;
                r.payload = {4'b0, b[0]};
            end
            if (eod) begin
                r.emit = 1'b1;
                r.res.status = utf8d_pkg::ST_INCOMPLETE;
            end
        end
        return r;
    endfunction

    // shortest encoding length of a value
    function automatic logic [2:0] form_length(input logic [30:0] c);
        logic [2:0] l;
        if (c < 31'h80)           l = 3'd1;
        else if (c < 31'h800)     l = 3'd2;
        else if (c < 31'h10000)   l = 3'd3;
        else if (c < 31'h200000)  l = 3'd4;
        else if (c < 31'h4000000) l = 3'd5;
        else                      l = 3'd6;
        return l;
    endfunction

    // Unicode scalar value that is not a noncharacter
    function automatic logic scalar_ok(input logic [30:0] c);
        return (c < 31'h110000)
            && (c[30:11] != 20'h0001B)          // surrogates D800-DFFF
            && (c < 31'hFDD0 || c > 31'hFDEF)
            && (c[15:1] != 15'h7FFF);           // low 16 bits FFFE/FFFF
    endfunction

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eod_reg;
    // sequence state
    logic [2:0]  rem_reg,  rem_next;
    logic [2:0]  len_reg,  len_next;
    logic [30:0] acc_reg,  acc_next;
    logic        strict_reg;

    logic        fire;
    lead_t       lead;
    logic [30:0] acc_shift;
    logic [2:0]  rem_dec;
    utf8d_pkg::result_t r0, r1;
    logic [1:0]  num;

    assign fire     = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            byte_reg <= data_byte;
            eod_reg  <= end_of_data;
        end
    end

    // decode one byte against the open sequence
    assign lead      = lead_decode(byte_reg, eod_reg);
    assign acc_shift = {acc_reg[24:0], byte_reg[5:0]};
    assign rem_dec   = rem_reg - 3'd1;

    always_comb
    begin
        r0       = '0;
        r1       = '0;
        num      = 2'd0;
        rem_next = rem_reg;
        len_next = len_reg;
        acc_next = acc_reg;
        if (rem_reg == 3'd0) begin
            // no sequence open
            if (lead.emit) begin
                r0  = lead.res;
                num = 2'd1;
            end else begin
                len_next = lead.len;
                rem_next = lead.len - 3'd1;
                acc_next = {26'd0, lead.payload};
            end
        end else if (byte_reg[7:6] == 2'b10) begin
            // continuation byte
            acc_next = acc_shift;
            rem_next = rem_dec;
            if (rem_dec == 3'd0) begin
                r0.byte_count = len_reg;
                num = 2'd1;
                if (form_length(acc_shift) != len_reg) begin
                    r0.status = utf8d_pkg::ST_INVALID;
                end else if (strict_reg && !scalar_ok(acc_shift)) begin
                    r0.status = utf8d_pkg::ST_INVALID;
                end else begin
                    r0.status = utf8d_pkg::ST_CHAR;
                    r0.code_point = acc_shift;
                end
                len_next = 3'd0;
                acc_next = '0;
            end else if (eod_reg) begin
                r0.status = utf8d_pkg::ST_INCOMPLETE;
                r0.byte_count = len_reg - rem_dec;
                num = 2'd1;
                rem_next = 3'd0;
                len_next = 3'd0;
                acc_next = '0;
            end
        end else begin
            // sequence cut short; byte then starts over as a lead
            r0.status = (byte_reg == 8'h00) ? utf8d_pkg::ST_INCOMPLETE
                                            : utf8d_pkg::ST_INVALID;
            r0.byte_count = len_reg - rem_reg;
            num = 2'd1;
            rem_next = 3'd0;
            len_next = 3'd0;
            acc_next = '0;
            if (lead.emit) begin
                r1  = lead.res;
                num = 2'd2;
            end else begin
                len_next = lead.len;
                rem_next = lead.len - 3'd1;
                acc_next = {26'd0, lead.payload};
            end
        end
        // flag the final result of this byte
        if (num == 2'd2) begin
            r1.last_of_run = 1'b1;
        end else begin
            r0.last_of_run = 1'b1;
        end
    end

    assign push.num  = fire ? num : 2'd0;
    assign push.res0 = r0;
    assign push.res1 = r1;

    // sequence state and strict mode register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rem_reg    <= 3'd0;
            len_reg    <= 3'd0;
            acc_reg    <= '0;
            strict_reg <= 1'b1;
        end else begin
            if (fire) begin
                rem_reg <= rem_next;
                len_reg <= len_next;
                acc_reg <= acc_next;
            end
            if (cfg_we) begin
                strict_reg <= cfg_strict;
            end
        end
    end

endmodule

// ----- hw/rtl/utf8d_res_fifo.sv -----
// utf8d_res_fifo: four-entry result queue, up to two writes and one read
// per cycle. Depends on utf8d_pkg (result_t, push_t).
module utf8d_res_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8d_pkg::push_t     push,
    output logic                 space_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output utf8d_pkg::result_t   out_res
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    utf8d_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          pop;
    logic [AW-1:0] wr_ptr1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    // room for a full run of two results
    assign space_ok  = (count_reg <= (AW+1)'(DEPTH - 2));
    assign wr_ptr1   = wr_ptr_reg + 1'b1;

    // storage
    always_ff @(posedge clk) begin
        if (push.num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.num == 2'd2) begin
            mem_reg[wr_ptr1] <= push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.num);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push.num) - (AW+1)'(pop);
        end
    end

endmodule

// ----- hw/rtl/utf8_validating_decoder.sv -----
// utf8_validating_decoder: streaming UTF-8 decoder with validation, top level.
// Depends on utf8d_pkg, utf8d_core and utf8d_res_fifo.
//
//  channel | handshake          | beat
//  --------+--------------------+-----------------------------------------
//  input   | in_valid/in_ready  | data_byte, end_of_data
//  output  | out_valid/out_ready| code_point, status, byte_count, last_of_run
//  config  | cfg_valid/cfg_ready| strict_scalar_check
//
// One byte per clock is accepted while the queue has room for two results;
// a byte passes the input register, its results the result queue. A byte that
// aborts a sequence and yields a second result takes two output beats, so
// such bytes are limited by the single result port of the four-entry queue.
// Reset clears the sequence state and sets strict mode; cfg_ready is always high.
// A stalled output fills the queue, then in_ready drops.
module utf8_validating_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] code_point,
    output logic [1:0]  status,
    output logic [2:0]  byte_count,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        strict_scalar_check
);

    utf8d_pkg::push_t   push;
    utf8d_pkg::result_t out_res;
    logic               space_ok;

    assign cfg_ready = 1'b1;

    // decode stage
    utf8d_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_strict  (strict_scalar_check),
        .space_ok    (space_ok),
        .push        (push)
    );

    // result queue
    utf8d_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign code_point  = out_res.code_point;
    assign status      = out_res.status;
    assign byte_count  = out_res.byte_count;
    assign last_of_run = out_res.last_of_run;

endmodule

// ----- hw/rtl/utf8d_checker.sv -----
// utf8d_checker: port-level assertions for the UTF-8 decoder, bound to the
// top level. Depends on utf8d_pkg (status codes).
module utf8d_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [30:0] code_point,
    input  logic [1:0]  status,
    input  logic [2:0]  byte_count
);

    // a stalled output beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(status))
        else $error("output beat dropped or changed while stalled");

    // only characters carry a value
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != utf8d_pkg::ST_CHAR |-> code_point == 31'd0)
        else $error("non-character result with nonzero code point");

    // a character covers one to six bytes
    a_char_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == utf8d_pkg::ST_CHAR |-> byte_count != 3'd0 && byte_count != 3'd7)
        else $error("character byte count out of range");

    // an incomplete sequence never holds all six bytes
    a_inc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == utf8d_pkg::ST_INCOMPLETE
            |-> byte_count != 3'd0 && byte_count != 3'd6 && byte_count != 3'd7)
        else $error("incomplete byte count out of range");

endmodule

bind utf8_validating_decoder utf8d_checker u_utf8d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .status     (status),
    .byte_count (byte_count)
);

// ----- bench/utf8d_stream_checker.sv -----
`timescale 1ns / 1ps
// utf8d_stream_checker: watches the byte, result and mode-write channels of the
// UTF-8 decoder, predicts each result beat and compares them in order.
// Depends on utf8d_pkg for the status codes and the result layout.
module utf8d_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [30:0] code_point,
    input  logic [1:0]  status,
    input  logic [2:0]  byte_count,
    input  logic        last_of_run,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        strict_scalar_check,
    output int          fail_count,
    output int          results_due
);

    // Decoder state as the stream has left it
    logic [2:0]  conts_left;
    logic [2:0]  seq_len;
    logic [30:0] payload_acc;
    logic        strict_mode;

    // Results predicted but not yet seen on the output
    utf8d_pkg::result_t pending_chars[$];
    utf8d_pkg::result_t byte_results[2];
    int          n_byte_results;
    int          n_fail = 0;

    // Shortest encoding length of a value
    function automatic logic [2:0] shortest_len(input logic [30:0] c);
        if (c < 31'h80)           return 3'd1;
        else if (c < 31'h800)     return 3'd2;
        else if (c < 31'h10000)   return 3'd3;
        else if (c < 31'h200000)  return 3'd4;
        else if (c < 31'h4000000) return 3'd5;
        else                      return 3'd6;
    endfunction

    // Unicode scalar that is neither a surrogate nor a noncharacter
    function automatic logic is_clean_scalar(input logic [30:0] c);
        logic [31:0] w;
        w = {1'b0, c};
        return (w < 32'h110000)
            && ((w & 32'hFFFFF800) != 32'hD800)
            && (w < 32'hFDD0 || w > 32'hFDEF)
            && ((w & 32'hFFFE) != 32'hFFFE);
    endfunction

    task automatic add_result(input logic [30:0] cp, input logic [1:0] st,
                              input logic [2:0] cnt);
        byte_results[n_byte_results].code_point  = (st == utf8d_pkg::ST_CHAR) ? cp : '0;
        byte_results[n_byte_results].status      = st;
        byte_results[n_byte_results].byte_count  = cnt;
        byte_results[n_byte_results].last_of_run = 1'b0;
        n_byte_results++;
    endtask

    // Byte seen with no sequence open
    task automatic take_lead(input logic [7:0] b, input logic eod);
        logic [2:0]  len;
        logic [30:0] bits;
        if (b < 8'h80) begin
            add_result({23'd0, b}, utf8d_pkg::ST_CHAR, 3'd1);
        end else if (b < 8'hC0 || b >= 8'hFE) begin
            add_result('0, utf8d_pkg::ST_INVALID, 3'd1);
        end else begin
            if (b < 8'hE0)      begin len = 3'd2; bits = {26'd0, b[4:0]}; end
            else if (b < 8'hF0) begin len = 3'd3; bits = {27'd0, b[3:0]}; end
            else if (b < 8'hF8) begin len = 3'd4; bits = {28'd0, b[2:0]}; end
            else if (b < 8'hFC) begin len = 3'd5; bits = {29'd0, b[1:0]}; end
            else                begin len = 3'd6; bits = {30'd0, b[0]};   end
            if (eod) begin
                add_result('0, utf8d_pkg::ST_INCOMPLETE, 3'd1);
            end else begin
                seq_len     = len;
                conts_left  = len - 3'd1;
                payload_acc = bits;
            end
        end
    endtask

    // Predict the results of one accepted input beat
    task automatic decode_byte(input logic [7:0] b, input logic eod);
        n_byte_results = 0;
        if (conts_left == 3'd0) begin
            take_lead(b, eod);
        end else if (b[7:6] == 2'b10) begin
            payload_acc = {payload_acc[24:0], b[5:0]};
            conts_left  = conts_left - 3'd1;
            if (conts_left == 3'd0) begin
                if (shortest_len(payload_acc) != seq_len)
                    add_result('0, utf8d_pkg::ST_INVALID, seq_len);
                else if (strict_mode && !is_clean_scalar(payload_acc))
                    add_result('0, utf8d_pkg::ST_INVALID, seq_len);
                else
                    add_result(payload_acc, utf8d_pkg::ST_CHAR, seq_len);
                seq_len     = '0;
                payload_acc = '0;
            end else if (eod) begin
                add_result('0, utf8d_pkg::ST_INCOMPLETE, seq_len - conts_left);
                conts_left  = '0;
                seq_len     = '0;
                payload_acc = '0;
            end
        end else begin
            // sequence cut short; the byte then starts over as a lead
            add_result('0, (b == 8'h00) ? utf8d_pkg::ST_INCOMPLETE
                                        : utf8d_pkg::ST_INVALID,
                       seq_len - conts_left);
            conts_left  = '0;
            seq_len     = '0;
            payload_acc = '0;
            take_lead(b, eod);
        end
        if (n_byte_results > 0)
            byte_results[n_byte_results - 1].last_of_run = 1'b1;
        for (int i = 0; i < n_byte_results; i++)
            pending_chars.push_back(byte_results[i]);
    endtask

    // Compare one output beat with the oldest prediction
    task automatic check_result();
        utf8d_pkg::result_t want;
        if (pending_chars.size() == 0) begin
            $error("unexpected result beat: code_point %h status %0d byte_count %0d",
                   code_point, status, byte_count);
            n_fail++;
        end else begin
            want = pending_chars.pop_front();
            if (code_point !== want.code_point) begin
                $error("code_point: expected %h, got %h", want.code_point, code_point);
                n_fail++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                n_fail++;
            end
            if (byte_count !== want.byte_count) begin
                $error("byte_count: expected %0d, got %0d", want.byte_count, byte_count);
                n_fail++;
            end
            if (last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, last_of_run);
                n_fail++;
            end
        end
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            conts_left  = '0;
            seq_len     = '0;
            payload_acc = '0;
            strict_mode = 1'b1;
            pending_chars.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                strict_mode = strict_scalar_check;
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                decode_byte(data_byte, end_of_data);
        end
        fail_count  <= n_fail;
        results_due <= pending_chars.size();
    end

endmodule

// ----- bench/utf8_validating_decoder_test.sv -----
`timescale 1ns / 1ps
// utf8_validating_decoder_test: drives byte streams and strict-mode writes into
// the decoder under random idling; depends on utf8_validating_decoder and
// utf8d_stream_checker, which predicts and compares the results.
module utf8_validating_decoder_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1520;

    logic        clk                 = 1'b0;
    logic        rst_n               = 1'b0;
    logic        in_valid            = 1'b0;
    logic [7:0]  data_byte           = 8'h00;
    logic        end_of_data         = 1'b0;
    logic        out_ready           = 1'b0;
    logic        cfg_valid           = 1'b0;
    logic        strict_scalar_check = 1'b1;

    wire         in_ready;
    wire         out_valid;
    wire         cfg_ready;
    wire  [30:0] code_point;
    wire  [1:0]  status;
    wire  [2:0]  byte_count;
    wire         last_of_run;

    int          fail_count;
    int          results_due;
    int          cycles     = 0;
    int          bytes_sent = 0;
    bit          in_burst   = 1'b0;
    bit          out_burst  = 1'b0;
    int          out_hold   = 0;

    utf8_validating_decoder dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .end_of_data         (end_of_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .code_point          (code_point),
        .status              (status),
        .byte_count          (byte_count),
        .last_of_run         (last_of_run),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .strict_scalar_check (strict_scalar_check)
    );

    utf8d_stream_checker chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .end_of_data         (end_of_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .code_point          (code_point),
        .status              (status),
        .byte_count          (byte_count),
        .last_of_run         (last_of_run),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .strict_scalar_check (strict_scalar_check),
        .fail_count          (fail_count),
        .results_due         (results_due)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random hold after each beat, with bursts of no holding
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if ($urandom_range(0, 39) == 0)
                    out_burst = !out_burst;
                out_hold = out_burst ? 0 : $urandom_range(0, 13);
            end
            if (out_hold > 0) begin
                out_ready <= 1'b0;
                out_hold = out_hold - 1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // One input beat; returns in the step where it is accepted
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_data <= eod;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // First value that needs len bytes
    function automatic logic [31:0] len_floor(input int len);
        case (len)
            1:       return 32'h0;
            2:       return 32'h80;
            3:       return 32'h800;
            4:       return 32'h10000;
            5:       return 32'h200000;
            6:       return 32'h4000000;
            default: return 32'h80000000;
        endcase
    endfunction

    // Value in the shortest form of len, often a surrogate, noncharacter or value past 10FFFF
    function automatic logic [31:0] pick_value(input int len);
        logic [31:0] v;
        v = $urandom_range(len_floor(len + 1) - 1, len_floor(len));
        if (len == 3 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0:       v = 32'hD800 + $urandom_range(0, 32'h7FF);
                1:       v = 32'hFDD0 + $urandom_range(0, 32'h1F);
                default: v = 32'hFFFE + $urandom_range(0, 1);
            endcase
        end
        else if (len == 4 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0:       v = ($urandom_range(1, 32'h1F) << 16) | 32'hFFFE
                             | $urandom_range(0, 1);
                1:       v = 32'h110000 + $urandom_range(0, 32'hEFFFF);
                default: v = $urandom_range(32'h10FFFF, 32'h10000);
            endcase
        end
        return v;
    endfunction

    // First keep bytes of the len-byte encoding of v
    task automatic send_seq(input logic [31:0] v, input int len, input int keep,
                            input logic eod_last);
        logic [7:0]  b;
        logic [7:0]  prefix;
        logic [31:0] sh;
        for (int i = 0; i < keep; i++) begin
            sh = v >> (6 * (len - 1 - i));
            if (i == 0 && len == 1) begin
                b = sh[7:0];
            end
            else if (i == 0) begin
                prefix = 8'hFF << (8 - len);
                b = prefix | sh[7:0];
            end
            else begin
                b = {2'b10, sh[5:0]};
            end
            send_byte(b, eod_last && (i == keep - 1));
        end
    endtask

    task automatic write_strict(input logic v);
        cfg_valid           <= 1'b1;
        strict_scalar_check <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain: all results in, then a quiet spell past the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly well-formed characters, plus overlong, cut-short and noise
    task automatic random_stream(input int n_bytes);
        int          goal;
        int          kind;
        int          len;
        int          keep;
        logic [31:0] v;
        logic [7:0]  b;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                len = $urandom_range(1, 6);
                send_seq(pick_value(len), len, len, $urandom_range(0, 15) == 0);
            end
            else if (kind < 65) begin
                // overlong form
                len = $urandom_range(2, 6);
                v = $urandom_range(len_floor(len) - 1, 0);
                send_seq(v, len, len, 1'b0);
            end
            else if (kind < 80) begin
                // sequence that never completes
                len  = $urandom_range(2, 6);
                keep = $urandom_range(1, len - 1);
                case ($urandom_range(0, 2))
                    0: send_seq(pick_value(len), len, keep, 1'b1);
                    1: begin
                        send_seq(pick_value(len), len, keep, 1'b0);
                        send_byte(8'h00, $urandom_range(0, 3) == 0);
                    end
                    default: begin
                        send_seq(pick_value(len), len, keep, 1'b0);
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10)
                            b[6] = 1'b1;
                        send_byte(b, $urandom_range(0, 7) == 0);
                    end
                endcase
            end
            else begin
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // strict mode out of reset
        // ASCII at both ends, a stray continuation, a byte that never leads
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // overlong NUL
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // surrogate
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // lead byte is the last byte
        send_byte(8'hC3, 1'b1);
        // data ends inside a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // NUL inside a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h00, 1'b0);
        // new lead aborts a sequence, then completes
        send_byte(8'hE2, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hFE, 1'b0);
        settle();

        // lenient mode: surrogate and the largest six-byte value pass
        write_strict(1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        settle();

        for (int p = 0; p < 4; p++) begin
            write_strict(!p[0]);
            random_stream(RANDOM_BYTES / 4);
            settle();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_core.sv
hw/rtl/utf8d_res_fifo.sv
hw/rtl/utf8_validating_decoder.sv
hw/rtl/utf8d_checker.sv
bench/utf8d_stream_checker.sv
bench/utf8_validating_decoder_test.sv
